>>> rtl/bll_pkg.sv
// shared types, constants and helpers of the linked list engine
package bll_pkg;

  localparam int CAPACITY = 64;
  localparam int NW       = $clog2(CAPACITY);
  localparam int LW       = $clog2(CAPACITY + 2);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;

  localparam logic [LW-1:0] SENT_F = LW'(CAPACITY);
  localparam logic [LW-1:0] SENT_B = LW'(CAPACITY + 1);

  typedef enum logic [3:0] {
    FN_PUSH_FRONT, FN_PUSH_BACK, FN_POP_FRONT, FN_POP_BACK,
    FN_FRONT, FN_BACK, FN_FIND, FN_GET_AT,
    FN_DEL_VAL, FN_DEL_AT, FN_CLEAR, FN_REVERSE,
    FN_DUMP_FWD, FN_DUMP_BWD, FN_INS_AFTER, FN_INS_BEFORE
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_CHK, ST_WR, ST_OUT
  } state_e;

  // one write into the node store: a value, or a logical next/prev link
  typedef struct packed {
    logic              en;
    logic              is_val;
    logic              prv;
    logic [LW-1:0]     addr;
    logic [LW-1:0]     link;
    logic [DATA_W-1:0] value;
  } wr_t;

  // registered read word of one node
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [LW-1:0]     fwd;
    logic [LW-1:0]     bwd;
  } rd_t;

  // one result word toward the output register
  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  fpos;
    logic [CNT_W-1:0]  total;
    logic              last;
  } emit_t;

  // lowest free node
  function automatic logic [NW-1:0] first_free(input logic [CAPACITY-1:0] m);
    logic [NW-1:0] r;
    r = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) r = NW'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/bll_store.sv
// node store: value and link memories plus the two sentinel link registers
module bll_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rev_i,
  input  logic            clear_i,
  input  logic            rd_en_i,
  input  logic [bll_pkg::NW-1:0] rd_addr_i,
  input  bll_pkg::wr_t    wr_i,
  output bll_pkg::rd_t    rd_o,
  output logic [bll_pkg::LW-1:0] sent_f_link_o,
  output logic [bll_pkg::LW-1:0] sent_b_link_o
);
  import bll_pkg::*;

  logic [DATA_W-1:0] val_mem [CAPACITY];
  logic [LW-1:0]     fwd_mem [CAPACITY];
  logic [LW-1:0]     bwd_mem [CAPACITY];
  rd_t               rd_q;
  logic [LW-1:0]     sf_q, sb_q;
  logic              wr_node, phys_bwd;
  logic [NW-1:0]     wr_idx;

  assign wr_node  = wr_i.addr < LW'(CAPACITY);
  assign phys_bwd = wr_i.prv ^ rev_i;
  assign wr_idx   = wr_i.addr[NW-1:0];

  // memory read and write ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q.value <= val_mem[rd_addr_i];
      rd_q.fwd   <= fwd_mem[rd_addr_i];
      rd_q.bwd   <= bwd_mem[rd_addr_i];
    end
    if (wr_i.en && wr_node) begin
      if (wr_i.is_val) begin
        val_mem[wr_idx] <= wr_i.value;
      end else if (phys_bwd) begin
        bwd_mem[wr_idx] <= wr_i.link;
      end else begin
        fwd_mem[wr_idx] <= wr_i.link;
      end
    end
  end

  // sentinel links, each sentinel keeps its one live link
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= SENT_B;
      sb_q <= SENT_F;
    end else if (clear_i) begin
      sf_q <= SENT_B;
      sb_q <= SENT_F;
    end else if (wr_i.en && !wr_node && !wr_i.is_val) begin
      if (wr_i.addr == SENT_F) sf_q <= wr_i.link;
      else sb_q <= wr_i.link;
    end
  end

  assign rd_o          = rd_q;
  assign sent_f_link_o = sf_q;
  assign sent_b_link_o = sb_q;

endmodule

>>> rtl/bll_seq.sv
// sequencer: walks the list, issues link writes, builds result words
module bll_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [3:0]                 func_i,
  input  logic [bll_pkg::DATA_W-1:0] value_i,
  input  logic [bll_pkg::POS_W-1:0]  position_i,
  input  logic [bll_pkg::CNT_W-1:0]  max_count_i,
  output bll_pkg::emit_t             emit_o,
  input  logic                       emit_ready_i,
  output logic                       rev_o,
  output logic                       clear_o,
  output logic                       rd_en_o,
  output logic [bll_pkg::NW-1:0]     rd_addr_o,
  output bll_pkg::wr_t               wr_o,
  input  bll_pkg::rd_t               rd_i,
  input  logic [bll_pkg::LW-1:0]     sent_f_i,
  input  logic [bll_pkg::LW-1:0]     sent_b_i
);
  import bll_pkg::*;

  state_e            state_q, state_d;
  func_e             func_q, func_d, func_in;
  logic [DATA_W-1:0] value_q, value_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  lim_q, lim_d, cnt_q, cnt_d, idx_q, idx_d, lim_in;
  logic              rev_q, rev_d, ins_q, ins_d;
  logic [CAPACITY-1:0] free_q, free_d;
  logic [LW-1:0]     cur_q, cur_d, wp_q, wp_d, wq_q, wq_d, wn_q, wn_d;
  logic [2:0]        wstep_q, wstep_d;
  logic              res_ok_q, res_ok_d, res_last_q, res_last_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic [POS_W-1:0]  res_fpos_q, res_fpos_d;

  logic [LW-1:0] nxt_l, prv_l, first_l, lastn_l, head_s, tail_s, alloc_l;
  logic [NW-1:0] alloc;
  logic          avail;

  // logical view of links under the reversed flag
  assign nxt_l   = rev_q ? rd_i.bwd : rd_i.fwd;
  assign prv_l   = rev_q ? rd_i.fwd : rd_i.bwd;
  assign first_l = rev_q ? sent_b_i : sent_f_i;
  assign lastn_l = rev_q ? sent_f_i : sent_b_i;
  assign head_s  = rev_q ? SENT_B : SENT_F;
  assign tail_s  = rev_q ? SENT_F : SENT_B;
  assign alloc   = first_free(free_q);
  assign alloc_l = LW'(alloc);
  assign avail   = |free_q;
  assign func_in = func_e'(func_i);
  assign lim_in  = (max_count_i < cnt_q) ? max_count_i : cnt_q;

  assign in_stall_o = state_q != ST_IDLE;
  assign rev_o      = rev_q;

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
      free_q  <= '1;
      wstep_q <= '0;
      idx_q   <= '0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
      free_q  <= free_d;
      wstep_q <= wstep_d;
      idx_q   <= idx_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    value_q    <= value_d;
    pos_q      <= pos_d;
    lim_q      <= lim_d;
    cur_q      <= cur_d;
    wp_q       <= wp_d;
    wq_q       <= wq_d;
    wn_q       <= wn_d;
    res_ok_q   <= res_ok_d;
    res_last_q <= res_last_d;
    res_data_q <= res_data_d;
    res_fpos_q <= res_fpos_d;
  end

  // next state and outputs
  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    value_d    = value_q;
    pos_d      = pos_q;
    lim_d      = lim_q;
    cnt_d      = cnt_q;
    rev_d      = rev_q;
    free_d     = free_q;
    cur_d      = cur_q;
    idx_d      = idx_q;
    wp_d       = wp_q;
    wq_d       = wq_q;
    wn_d       = wn_q;
    ins_d      = ins_q;
    wstep_d    = wstep_q;
    res_ok_d   = res_ok_q;
    res_last_d = res_last_q;
    res_data_d = res_data_q;
    res_fpos_d = res_fpos_q;
    clear_o    = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = cur_q[NW-1:0];
    wr_o       = '0;
    emit_o       = '0;
    emit_o.ok    = res_ok_q;
    emit_o.data  = res_data_q;
    emit_o.fpos  = res_fpos_q;
    emit_o.total = cnt_q;
    emit_o.last  = res_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d     = func_in;
          value_d    = value_i;
          pos_d      = position_i;
          idx_d      = '0;
          wstep_d    = '0;
          res_ok_d   = 1'b0;
          res_data_d = '0;
          res_fpos_d = '0;
          res_last_d = 1'b1;
          state_d    = ST_OUT;
          unique case (func_in)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              if (avail) begin
                wp_d    = (func_in == FN_PUSH_FRONT) ? head_s : lastn_l;
                wq_d    = (func_in == FN_PUSH_FRONT) ? first_l : tail_s;
                ins_d   = 1'b1;
                state_d = ST_WR;
              end
            end
            FN_POP_FRONT, FN_FRONT, FN_FIND, FN_DEL_VAL: begin
              if (cnt_q != '0) begin
                rd_en_o   = 1'b1;
                rd_addr_o = first_l[NW-1:0];
                cur_d     = first_l;
                state_d   = ST_CHK;
              end
            end
            FN_POP_BACK, FN_BACK: begin
              if (cnt_q != '0) begin
                rd_en_o   = 1'b1;
                rd_addr_o = lastn_l[NW-1:0];
                cur_d     = lastn_l;
                state_d   = ST_CHK;
              end
            end
            FN_GET_AT, FN_DEL_AT, FN_INS_AFTER, FN_INS_BEFORE: begin
              if ({1'b0, position_i} < cnt_q &&
                  (avail || func_in == FN_GET_AT || func_in == FN_DEL_AT)) begin
                rd_en_o   = 1'b1;
                rd_addr_o = first_l[NW-1:0];
                cur_d     = first_l;
                state_d   = ST_CHK;
              end
            end
            FN_CLEAR: begin
              clear_o  = 1'b1;
              free_d   = '1;
              cnt_d    = '0;
              rev_d    = 1'b0;
              res_ok_d = 1'b1;
            end
            FN_REVERSE: begin
              if (cnt_q > CNT_W'(1)) rev_d = ~rev_q;
              res_ok_d = 1'b1;
            end
            FN_DUMP_FWD, FN_DUMP_BWD: begin
              lim_d = lim_in;
              if (lim_in != '0) begin
                rd_en_o   = 1'b1;
                rd_addr_o = (func_in == FN_DUMP_FWD) ? first_l[NW-1:0] : lastn_l[NW-1:0];
                cur_d     = (func_in == FN_DUMP_FWD) ? first_l : lastn_l;
                state_d   = ST_CHK;
              end
            end
          endcase
        end
      end

      ST_CHK: begin
        case (func_q)
          FN_POP_FRONT, FN_POP_BACK, FN_FRONT, FN_BACK: begin
            res_ok_d   = 1'b1;
            res_data_d = rd_i.value;
            if (func_q == FN_POP_FRONT || func_q == FN_POP_BACK) begin
              wp_d = prv_l; wq_d = nxt_l; wn_d = cur_q; ins_d = 1'b0;
              state_d = ST_WR;
            end else begin
              state_d = ST_OUT;
            end
          end
          FN_FIND, FN_DEL_VAL: begin
            if (rd_i.value == value_q) begin
              res_ok_d = 1'b1;
              if (func_q == FN_FIND) begin
                res_fpos_d = idx_q[POS_W-1:0];
                state_d    = ST_OUT;
              end else begin
                res_data_d = value_q;
                wp_d = prv_l; wq_d = nxt_l; wn_d = cur_q; ins_d = 1'b0;
                state_d = ST_WR;
              end
            end else if ((idx_q + CNT_W'(1)) == cnt_q) begin
              state_d = ST_OUT;
            end else begin
              idx_d     = idx_q + CNT_W'(1);
              rd_en_o   = 1'b1;
              rd_addr_o = nxt_l[NW-1:0];
              cur_d     = nxt_l;
            end
          end
          FN_GET_AT, FN_DEL_AT, FN_INS_AFTER, FN_INS_BEFORE: begin
            if (idx_q == {1'b0, pos_q}) begin
              if (func_q == FN_GET_AT) begin
                res_ok_d   = 1'b1;
                res_data_d = rd_i.value;
                state_d    = ST_OUT;
              end else if (func_q == FN_DEL_AT) begin
                res_ok_d   = 1'b1;
                res_data_d = rd_i.value;
                wp_d = prv_l; wq_d = nxt_l; wn_d = cur_q; ins_d = 1'b0;
                state_d = ST_WR;
              end else begin
                wp_d    = (func_q == FN_INS_AFTER) ? cur_q : prv_l;
                wq_d    = (func_q == FN_INS_AFTER) ? nxt_l : cur_q;
                ins_d   = 1'b1;
                state_d = ST_WR;
              end
            end else begin
              idx_d     = idx_q + CNT_W'(1);
              rd_en_o   = 1'b1;
              rd_addr_o = nxt_l[NW-1:0];
              cur_d     = nxt_l;
            end
          end
          FN_DUMP_FWD, FN_DUMP_BWD: begin
            res_ok_d   = 1'b1;
            res_data_d = rd_i.value;
            res_last_d = (idx_q + CNT_W'(1)) == lim_q;
            state_d    = ST_OUT;
          end
          default: state_d = ST_IDLE;
        endcase
      end

      ST_WR: begin
        wr_o.en    = 1'b1;
        wr_o.value = value_q;
        wstep_d    = wstep_q + 3'd1;
        if (ins_q) begin
          // new node between p and q, one write per cycle
          case (wstep_q)
            3'd0: begin wr_o.is_val = 1'b1; wr_o.addr = alloc_l; end
            3'd1: begin wr_o.addr = alloc_l; wr_o.link = wq_q; end
            3'd2: begin wr_o.prv = 1'b1; wr_o.addr = alloc_l; wr_o.link = wp_q; end
            3'd3: begin wr_o.prv = 1'b1; wr_o.addr = wq_q; wr_o.link = alloc_l; end
            default: begin
              wr_o.addr     = wp_q;
              wr_o.link     = alloc_l;
              free_d[alloc] = 1'b0;
              cnt_d         = cnt_q + CNT_W'(1);
              res_ok_d      = 1'b1;
              state_d       = ST_OUT;
            end
          endcase
        end else begin
          // bridge p and q around the removed node
          if (wstep_q == 3'd0) begin
            wr_o.addr = wp_q;
            wr_o.link = wq_q;
          end else begin
            wr_o.prv = 1'b1;
            wr_o.addr = wq_q;
            wr_o.link = wp_q;
            free_d[wn_q[NW-1:0]] = 1'b1;
            cnt_d   = cnt_q - CNT_W'(1);
            state_d = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        emit_o.valid = 1'b1;
        if (emit_ready_i) begin
          if ((func_q == FN_DUMP_FWD || func_q == FN_DUMP_BWD) && !res_last_q) begin
            idx_d     = idx_q + CNT_W'(1);
            rd_en_o   = 1'b1;
            rd_addr_o = (func_q == FN_DUMP_FWD) ? nxt_l[NW-1:0] : prv_l[NW-1:0];
            cur_d     = (func_q == FN_DUMP_FWD) ? nxt_l : prv_l;
            state_d   = ST_CHK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

>>> rtl/bounded_linked_list_engine_unit.sv
// Doubly linked list engine over a pool of 64 nodes. One request word is
// taken while the engine is idle; the engine then stalls its input until the
// last result word has entered the output register, which can hold a finished
// word while the next request is already accepted. All node work goes through
// one node store with a read port and a write port, read at most once per
// cycle by the walk sequencer, so the time per request is set by that walk:
// front, back and pops read an end node, find, delete by value and indexed
// requests walk k nodes from the front (up to 64), pushes and inserts write
// the new node and relink its neighbours, and pops and deletes relink around
// the removed node. A dump reads each element and sends it out before it
// reads the next, waiting on any output stall. No clearing pass is needed after reset.
module bounded_linked_list_engine_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [3:0]                 func_i,
  input  logic signed [31:0]         value_i,
  input  logic [5:0]                 position_i,
  input  logic [6:0]                 max_count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       ok_o,
  output logic signed [31:0]         data_o,
  output logic [5:0]                 found_position_o,
  output logic [6:0]                 element_total_o,
  output logic                       is_empty_o,
  output logic                       last_o
);
  import bll_pkg::*;

  emit_t         emit;
  logic          emit_ready;
  logic          rev, clear, rd_en;
  logic [NW-1:0] rd_addr;
  wr_t           wr;
  rd_t           rd;
  logic [LW-1:0] sent_f, sent_b;
  logic          out_valid_q;
  emit_t         out_q;

  bll_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .max_count_i  (max_count_i),
    .emit_o       (emit),
    .emit_ready_i (emit_ready),
    .rev_o        (rev),
    .clear_o      (clear),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .wr_o         (wr),
    .rd_i         (rd),
    .sent_f_i     (sent_f),
    .sent_b_i     (sent_b)
  );

  bll_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rev_i         (rev),
    .clear_i       (clear),
    .rd_en_i       (rd_en),
    .rd_addr_i     (rd_addr),
    .wr_i          (wr),
    .rd_o          (rd),
    .sent_f_link_o (sent_f),
    .sent_b_link_o (sent_b)
  );

  // output word register
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready && emit.valid) out_q <= emit;
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = out_q.ok;
  assign data_o           = out_q.data;
  assign found_position_o = out_q.fpos;
  assign element_total_o  = out_q.total;
  assign is_empty_o       = out_q.total == '0;
  assign last_o           = out_q.last;

endmodule

>>> dv/bounded_linked_list_engine_unit_tb.sv
// testbench of the linked list engine: directed table and a full-pool pass, then random requests against a predictor
`timescale 1ns / 100ps

module bounded_linked_list_engine_unit_tb;
  import bll_pkg::*;

  localparam int CAP = 64;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         func;
  logic signed [31:0] value;
  logic [5:0]         position;
  logic [6:0]         max_count;
  logic               out_valid;
  logic               out_stall;
  logic               ok;
  logic signed [31:0] data;
  logic [5:0]         found_position;
  logic [6:0]         element_total;
  logic               is_empty;
  logic               last;

  // one expected result word
  typedef struct {
    logic        ok;
    logic [31:0] data;
    logic [5:0]  fpos;
    logic [6:0]  total;
    logic        empty;
    logic        last;
  } answer_t;

  // one directed row; has_ans marks a typed-in answer for single-word requests
  typedef struct {
    func_e       fn;
    logic [31:0] val;
    logic [5:0]  pos;
    logic [6:0]  maxc;
    logic        has_ans;
    logic        a_ok;
    logic [31:0] a_data;
    logic [6:0]  a_total;
  } row_t;

  answer_t answers_q[$];
  int      error_count;
  int      send_idle_pct;
  int      recv_idle_pct;

  // predictor copy of the list: logical order held as an array
  logic [31:0] list_vals[$];

  bounded_linked_list_engine_unit DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .value_i(value), .position_i(position), .max_count_i(max_count),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .ok_o(ok), .data_o(data), .found_position_o(found_position),
    .element_total_o(element_total), .is_empty_o(is_empty), .last_o(last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic answer_t make_answer(input logic a_ok, input logic [31:0] d,
                                          input logic [5:0] fp, input logic l);
    answer_t a;
    a.ok = a_ok;
    a.data = d;
    a.fpos = fp;
    a.total = 7'(list_vals.size());
    a.empty = (list_vals.size() == 0);
    a.last = l;
    return a;
  endfunction

  // expected words of one request; updates the list copy
  task automatic predict_request(input func_e fn, input logic [31:0] v,
                                 input logic [5:0] p, input logic [6:0] mc);
    int n;
    int lim;
    logic r_ok;
    logic [31:0] r_data;
    logic [5:0] r_fpos;
    r_ok = 1'b0;
    r_data = '0;
    r_fpos = '0;
    n = list_vals.size();
    case (fn)
      FN_PUSH_FRONT: if (n < CAP) begin list_vals.push_front(v); r_ok = 1'b1; end
      FN_PUSH_BACK:  if (n < CAP) begin list_vals.push_back(v); r_ok = 1'b1; end
      FN_POP_FRONT:  if (n > 0) begin r_data = list_vals.pop_front(); r_ok = 1'b1; end
      FN_POP_BACK:   if (n > 0) begin r_data = list_vals.pop_back(); r_ok = 1'b1; end
      FN_FRONT:      if (n > 0) begin r_data = list_vals[0]; r_ok = 1'b1; end
      FN_BACK:       if (n > 0) begin r_data = list_vals[n-1]; r_ok = 1'b1; end
      FN_FIND, FN_DEL_VAL: begin
        for (int i = 0; i < n; i++) begin
          if (list_vals[i] == v) begin
            r_ok = 1'b1;
            if (fn == FN_FIND) r_fpos = 6'(i);
            else begin r_data = v; list_vals.delete(i); end
            break;
          end
        end
      end
      FN_GET_AT, FN_DEL_AT: if (p < n) begin
        r_ok = 1'b1;
        r_data = list_vals[p];
        if (fn == FN_DEL_AT) list_vals.delete(p);
      end
      FN_CLEAR:   begin list_vals.delete(); r_ok = 1'b1; end
      FN_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          r_data = list_vals[i];
          list_vals[i] = list_vals[n-1-i];
          list_vals[n-1-i] = r_data;
        end
        r_data = '0;
        r_ok = 1'b1;
      end
      FN_DUMP_FWD, FN_DUMP_BWD: begin
        lim = (int'(mc) < n) ? int'(mc) : n;
        if (lim == 0) answers_q.push_back(make_answer(1'b0, '0, '0, 1'b1));
        for (int i = 0; i < lim; i++)
          answers_q.push_back(make_answer(1'b1,
              (fn == FN_DUMP_FWD) ? list_vals[i] : list_vals[n-1-i], '0, i == lim - 1));
        return;
      end
      default: if (p < n && n < CAP) begin
        list_vals.insert((fn == FN_INS_AFTER) ? p + 1 : p, v);
        r_ok = 1'b1;
      end
    endcase
    answers_q.push_back(make_answer(r_ok, r_data, r_fpos, 1'b1));
  endtask

  // drive one request word and wait for acceptance
  task automatic send_request(input func_e fn, input logic [31:0] v,
                              input logic [5:0] p, input logic [6:0] mc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    predict_request(fn, v, p, mc);
    in_valid <= 1'b1;
    func <= fn;
    value <= v;
    position <= p;
    max_count <= mc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        error_count++;
      end else begin
        a = answers_q.pop_front();
        if (ok !== a.ok) report_mismatch("ok", 32'(ok), 32'(a.ok));
        if (data !== a.data) report_mismatch("data", data, a.data);
        if (found_position !== a.fpos)
          report_mismatch("found_position", 32'(found_position), 32'(a.fpos));
        if (element_total !== a.total)
          report_mismatch("element_total", 32'(element_total), 32'(a.total));
        if (is_empty !== a.empty) report_mismatch("is_empty", 32'(is_empty), 32'(a.empty));
        if (last !== a.last) report_mismatch("last", 32'(last), 32'(a.last));
      end
    end
  end

  // random value from a small pool so find and delete hit often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return 32'($urandom_range(7));
      1: return 32'h8000_0000 | 32'($urandom_range(3));
      2: return 32'h7fff_fffc | 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random(input int count);
    func_e fn;
    int sz;
    for (int k = 0; k < count; k++) begin
      sz = list_vals.size();
      // favor growth, keep edits in range most of the time
      if ($urandom_range(99) < 30) fn = ($urandom_range(1)) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      else fn = func_e'($urandom_range(15));
      if (fn == FN_CLEAR && $urandom_range(7) != 0) fn = FN_PUSH_BACK;
      send_request(fn, pick_value(),
                   ($urandom_range(3) == 0 || sz == 0) ? 6'($urandom())
                                                       : 6'($urandom_range(sz - 1)),
                   ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(8)));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  row_t dir_rows[$];

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = '0;
    value = '0;
    position = '0;
    max_count = '0;
    out_stall = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed rows: empty-list errors first, then extremes
    dir_rows = '{
      '{FN_POP_FRONT,  32'h0,         6'd0,  7'd0,   1'b1, 1'b0, 32'h0, 7'd0},
      '{FN_BACK,       32'h0,         6'd0,  7'd0,   1'b1, 1'b0, 32'h0, 7'd0},
      '{FN_DUMP_FWD,   32'h0,         6'd0,  7'd64,  1'b1, 1'b0, 32'h0, 7'd0},
      '{FN_GET_AT,     32'h0,         6'd0,  7'd0,   1'b1, 1'b0, 32'h0, 7'd0},
      '{FN_INS_AFTER,  32'h5,         6'd0,  7'd0,   1'b1, 1'b0, 32'h0, 7'd0},
      '{FN_REVERSE,    32'h0,         6'd0,  7'd0,   1'b1, 1'b1, 32'h0, 7'd0},
      '{FN_PUSH_BACK,  32'h7fff_ffff, 6'd0,  7'd0,   1'b1, 1'b1, 32'h0, 7'd1},
      '{FN_PUSH_FRONT, 32'h8000_0000, 6'd63, 7'd0,   1'b1, 1'b1, 32'h0, 7'd2},
      '{FN_PUSH_BACK,  32'hffff_ffff, 6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_INS_BEFORE, 32'h1,         6'd1,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_INS_AFTER,  32'h2,         6'd3,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_FIND,       32'hffff_ffff, 6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_FIND,       32'h1234,      6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_DUMP_FWD,   32'h0,         6'd0,  7'd127, 1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_DUMP_BWD,   32'h0,         6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_REVERSE,    32'h0,         6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_DUMP_BWD,   32'h0,         6'd0,  7'd2,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_GET_AT,     32'h0,         6'd63, 7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_FRONT,      32'h0,         6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_DEL_VAL,    32'h7fff_ffff, 6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_DEL_AT,     32'h0,         6'd1,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_POP_BACK,   32'h0,         6'd0,  7'd0,   1'b0, 1'b0, 32'h0, 7'd0},
      '{FN_CLEAR,      32'h0,         6'd0,  7'd0,   1'b1, 1'b1, 32'h0, 7'd0}
    };
    send_idle_pct = 13;
    recv_idle_pct = 51;
    foreach (dir_rows[r]) begin
      send_request(dir_rows[r].fn, dir_rows[r].val, dir_rows[r].pos, dir_rows[r].maxc);
      // replace the predicted word by the typed-in one where given
      if (dir_rows[r].has_ans) begin
        answers_q[$].ok = dir_rows[r].a_ok;
        answers_q[$].data = dir_rows[r].a_data;
        answers_q[$].total = dir_rows[r].a_total;
        answers_q[$].empty = (dir_rows[r].a_total == 0);
      end
    end

    // fill the pool to full, hit the full case, dump it all
    for (int k = 0; k < CAP; k++) send_request(FN_PUSH_BACK, $urandom(), 6'd0, 7'd0);
    send_request(FN_PUSH_FRONT, 32'h1, 6'd0, 7'd0);
    send_request(FN_INS_BEFORE, 32'h1, 6'd63, 7'd0);
    send_request(FN_REVERSE, 32'h0, 6'd0, 7'd0);
    send_request(FN_DUMP_FWD, 32'h0, 6'd0, 7'd64);
    send_request(FN_DEL_AT, 32'h0, 6'd63, 7'd0);
    send_request(FN_CLEAR, 32'h0, 6'd0, 7'd0);

    run_random(20);
    send_idle_pct = 51;
    recv_idle_pct = 13;
    run_random(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(20);
    drain();

    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
